FILE: rtl/bct_pkg.sv
// Shared widths, register indexes and pipeline types for block to CHS translation.
`default_nettype none

package bct_pkg;

	// Field widths of the request, the result and the configuration registers.
	localparam int BLOCK_W     = 16;
	localparam int CYL_W       = 29;
	localparam int HEAD_W      = 4;
	localparam int SECTOR_W    = 8;
	localparam int BSHIFT_W    = 3;
	localparam int SSHIFT_W    = 4;
	localparam int SPT_W       = 8;
	localparam int HCOUNT_W    = 5;
	localparam int SCYL_W      = 16;
	localparam int SHEAD_W     = 4;

	// Base block size is 128 bytes, so its log2 is seven.
	localparam int BASE_LOG2   = 7;

	// Internal arithmetic widths.
	localparam int PERCYL_W    = SPT_W + HCOUNT_W;      // sectors per cylinder
	localparam int REM_W       = PERCYL_W;              // partial remainder
	localparam int SHIFTED_W   = BLOCK_W + 14;          // block times sectors per block
	localparam int BASE_W      = 29;                    // partition start in sectors
	localparam int FULL_W      = 31;                    // absolute sector number
	localparam int CYL_STEPS   = FULL_W;                // quotient bits of the cylinder
	localparam int HEAD_STEPS  = HCOUNT_W;              // quotient bits of the head
	localparam int HEAD_PAD_W  = FULL_W - HEAD_STEPS;

	// APB register map.
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;

	typedef enum logic [2:0] {
		REG_BLOCK_SHIFT  = 3'd0,
		REG_SECTOR_SHIFT = 3'd1,
		REG_SPT          = 3'd2,
		REG_HEAD_COUNT   = 3'd3,
		REG_START_CYL    = 3'd4,
		REG_START_HEAD   = 3'd5
	} reg_idx_t;

	// Configuration values that the datapath reads, with the ones derived from them.
	typedef struct packed {
		logic [BSHIFT_W-1:0] block_shift;
		logic [SSHIFT_W-1:0] sector_size_shift;
		logic [SPT_W-1:0]    track_sectors;
		logic [PERCYL_W-1:0] per_cyl;
		logic [BASE_W-1:0]   base;
	} cfg_t;

	// Payload handed from one divider cell to the next.
	typedef struct packed {
		logic              zero;   // geometry has no sectors, result forced to zero
		logic [REM_W-1:0]  rem;    // partial remainder
		logic [FULL_W-1:0] word;   // dividend bits still to use, quotient bits shifted in
		logic [CYL_W-1:0]  cyl;    // cylinder, carried through the head cells
	} cell_t;

endpackage

`default_nettype wire

FILE: rtl/block_to_chs_translate.sv
// Block to CHS translation: a filesystem block number becomes a cylinder/head/sector address.
//
// Usage: a block number is presented on the s_axis channel and accepted when
// s_axis_tvalid and s_axis_tready are both high. The address of the block's
// first sector leaves on the m_axis channel, one result per request, in order.
// The geometry and partition start are set through the APB port while no
// request is in flight.
// Each request passes through three front stages (capture, scale to sectors,
// add partition start), a row of 31 divider cells for the cylinder, 5 cells
// for the head and sector, and the output register. The row of cells takes a
// new request every cycle while the receiver does not stall, so the sustained
// rate is one request per cycle while m_axis_tready stays high.
// When the receiver stalls, each stage holds its request and empty stages
// keep filling, so s_axis_tready falls only once every stage up to the
// input is occupied.
// Reset empties the pipeline and loads the default geometry: 512-byte blocks,
// 512-byte sectors, 63 sectors per track, 16 heads, partition at cylinder 0.
`default_nettype none

module block_to_chs_translate (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Requests
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] block_number
	// Results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata    // [28:0] cylinder, [32:29] head, [40:33] sector
);

	localparam int NCELLS = bct_pkg::CYL_STEPS + bct_pkg::HEAD_STEPS;

	bct_pkg::cfg_t        cfg;
	logic                 cell_v   [NCELLS+1];
	logic                 cell_r   [NCELLS+1];
	bct_pkg::cell_t       cell_d   [NCELLS+1];
	bct_pkg::cell_t       head_in;
	logic                 out_ready;
	logic                 m_tvalid_q;
	logic [47:0]          m_tdata_q;
	bct_pkg::cell_t       last;

	bct_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_in  (s_axis_tvalid),
		.block_in  (s_axis_tdata),
		.ready_out (s_axis_tready),
		.valid_out (cell_v[0]),
		.data_out  (cell_d[0]),
		.ready_in  (cell_r[0])
	);

	// Cylinder cells divide by the sectors per cylinder.
	for (genvar i = 0; i < bct_pkg::CYL_STEPS; i++) begin : g_cyl
		bct_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.divisor   (cfg.per_cyl),
			.valid_in  (cell_v[i]),
			.data_in   (cell_d[i]),
			.ready_out (cell_r[i]),
			.valid_out (cell_v[i+1]),
			.data_out  (cell_d[i+1]),
			.ready_in  (cell_r[i+1])
		);
	end

	// Hand-off: the quotient becomes the cylinder, and the remainder is split so
	// that its high bits start the head division and its low five bits follow.
	always_comb begin
		head_in      = cell_d[bct_pkg::CYL_STEPS];
		head_in.cyl  = cell_d[bct_pkg::CYL_STEPS].word[bct_pkg::CYL_W-1:0];
		head_in.rem  = bct_pkg::REM_W'(
			cell_d[bct_pkg::CYL_STEPS].rem[bct_pkg::REM_W-1:bct_pkg::HEAD_STEPS]);
		head_in.word = {cell_d[bct_pkg::CYL_STEPS].rem[bct_pkg::HEAD_STEPS-1:0],
			bct_pkg::HEAD_PAD_W'(0)};
	end

	// Head cells divide the remainder by the sectors per track.
	for (genvar j = 0; j < bct_pkg::HEAD_STEPS; j++) begin : g_head
		localparam int K = bct_pkg::CYL_STEPS + j;
		bct_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.divisor   (bct_pkg::REM_W'(cfg.track_sectors)),
			.valid_in  (cell_v[K]),
			.data_in   ((j == 0) ? head_in : cell_d[K]),
			.ready_out (cell_r[K]),
			.valid_out (cell_v[K+1]),
			.data_out  (cell_d[K+1]),
			.ready_in  (cell_r[K+1])
		);
	end

	// Output register; a geometry without sectors gives an all-zero address.
	assign last      = cell_d[NCELLS];
	assign out_ready = !m_tvalid_q || m_axis_tready;
	assign cell_r[NCELLS] = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_ready) begin
			m_tvalid_q <= cell_v[NCELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && cell_v[NCELLS]) begin
			if (last.zero) begin
				m_tdata_q <= '0;
			end else begin
				m_tdata_q <= {7'd0,
					last.rem[bct_pkg::SECTOR_W-1:0],
					last.word[bct_pkg::HEAD_W-1:0],
					last.cyl};
			end
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

endmodule

`default_nettype wire

FILE: rtl/bct_cfg.sv
// APB configuration registers and the geometry values derived from them.
`default_nettype none

module bct_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bct_pkg::PADDR_W-1:0] paddr,
	input  wire logic [bct_pkg::PDATA_W-1:0] pwdata,
	output logic      [bct_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	output bct_pkg::cfg_t                    cfg
);

	logic [bct_pkg::BSHIFT_W-1:0] block_shift_q;
	logic [bct_pkg::SSHIFT_W-1:0] sector_shift_q;
	logic [bct_pkg::SPT_W-1:0]    spt_q;
	logic [bct_pkg::HCOUNT_W-1:0] head_count_q;
	logic [bct_pkg::SCYL_W-1:0]   start_cyl_q;
	logic [bct_pkg::SHEAD_W-1:0]  start_head_q;
	logic [bct_pkg::PERCYL_W-1:0] per_cyl_q;
	logic [bct_pkg::BASE_W-1:0]   base_q;
	logic                         wr_en;
	bct_pkg::reg_idx_t            idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = bct_pkg::reg_idx_t'(paddr[4:2]);

	// Register writes; indexes past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_shift_q  <= 3'd2;
			sector_shift_q <= 4'd9;
			spt_q          <= 8'd63;
			head_count_q   <= 5'd16;
			start_cyl_q    <= '0;
			start_head_q   <= '0;
		end else if (wr_en) begin
			unique case (idx)
				bct_pkg::REG_BLOCK_SHIFT:  block_shift_q  <= pwdata[bct_pkg::BSHIFT_W-1:0];
				bct_pkg::REG_SECTOR_SHIFT: sector_shift_q <= pwdata[bct_pkg::SSHIFT_W-1:0];
				bct_pkg::REG_SPT:          spt_q          <= pwdata[bct_pkg::SPT_W-1:0];
				bct_pkg::REG_HEAD_COUNT:   head_count_q   <= pwdata[bct_pkg::HCOUNT_W-1:0];
				bct_pkg::REG_START_CYL:    start_cyl_q    <= pwdata[bct_pkg::SCYL_W-1:0];
				bct_pkg::REG_START_HEAD:   start_head_q   <= pwdata[bct_pkg::SHEAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Derived geometry: sectors per cylinder first, then the partition start,
	// which is built from the registered sectors per cylinder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_cyl_q <= bct_pkg::PERCYL_W'(63 * 16);
			base_q    <= '0;
		end else begin
			per_cyl_q <= bct_pkg::PERCYL_W'(spt_q * head_count_q);
			base_q    <= bct_pkg::BASE_W'(start_head_q * spt_q)
				+ bct_pkg::BASE_W'(start_cyl_q * per_cyl_q);
		end
	end

	// Read back of the written registers.
	always_comb begin
		prdata = '0;
		unique case (idx)
			bct_pkg::REG_BLOCK_SHIFT:  prdata = bct_pkg::PDATA_W'(block_shift_q);
			bct_pkg::REG_SECTOR_SHIFT: prdata = bct_pkg::PDATA_W'(sector_shift_q);
			bct_pkg::REG_SPT:          prdata = bct_pkg::PDATA_W'(spt_q);
			bct_pkg::REG_HEAD_COUNT:   prdata = bct_pkg::PDATA_W'(head_count_q);
			bct_pkg::REG_START_CYL:    prdata = bct_pkg::PDATA_W'(start_cyl_q);
			bct_pkg::REG_START_HEAD:   prdata = bct_pkg::PDATA_W'(start_head_q);
			default:                   prdata = '0;
		endcase
	end

	always_comb begin
		cfg.block_shift       = block_shift_q;
		cfg.sector_size_shift = sector_shift_q;
		cfg.track_sectors     = spt_q;
		cfg.per_cyl           = per_cyl_q;
		cfg.base              = base_q;
	end

endmodule

`default_nettype wire

FILE: rtl/bct_front.sv
// Front stages: capture the block number, scale it to sectors and add the partition start.
`default_nettype none

module bct_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bct_pkg::cfg_t               cfg,
	input  wire logic                        valid_in,
	input  wire logic [bct_pkg::BLOCK_W-1:0] block_in,
	output logic                             ready_out,
	output logic                             valid_out,
	output bct_pkg::cell_t                   data_out,
	input  wire logic                        ready_in
);

	logic                           v_s1, v_s2, v_s3;
	logic [bct_pkg::BLOCK_W-1:0]    block_s1;
	logic [bct_pkg::SHIFTED_W-1:0]  shifted_s2;
	logic [bct_pkg::FULL_W-1:0]     full_s3;
	logic                           zero_s3;
	logic                           rdy1, rdy2, rdy3;
	logic [3:0]                     blk_log;
	logic [3:0]                     shamt;
	logic                           spb_ok;
	logic [bct_pkg::SHIFTED_W-1:0]  shifted;

	// Each stage moves on when it is empty or the next one takes its request.
	assign rdy3      = !v_s3 || ready_in;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign ready_out = rdy1;

	// Sectors per block is a power of two, or zero when a block is smaller than a sector.
	always_comb begin
		blk_log = 4'(bct_pkg::BASE_LOG2) + {1'b0, cfg.block_shift};
		spb_ok  = cfg.sector_size_shift <= blk_log;
		shamt   = blk_log - cfg.sector_size_shift;
		shifted = spb_ok ? (bct_pkg::SHIFTED_W'(block_s1) << shamt) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= valid_in;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && valid_in) block_s1 <= block_in;
		if (rdy2 && v_s1) shifted_s2 <= shifted;
		if (rdy3 && v_s2) begin
			full_s3 <= bct_pkg::FULL_W'(shifted_s2) + bct_pkg::FULL_W'(cfg.base);
			zero_s3 <= cfg.per_cyl == '0;
		end
	end

	// The first divider cell starts with an empty remainder.
	assign valid_out = v_s3;
	always_comb begin
		data_out.zero = zero_s3;
		data_out.rem  = '0;
		data_out.word = full_s3;
		data_out.cyl  = '0;
	end

endmodule

`default_nettype wire

FILE: rtl/bct_cell.sv
// One restoring-division cell: forms one quotient bit and passes the request on.
`default_nettype none

module bct_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [bct_pkg::REM_W-1:0] divisor,
	input  wire logic                      valid_in,
	input  wire bct_pkg::cell_t            data_in,
	output logic                           ready_out,
	output logic                           valid_out,
	output bct_pkg::cell_t                 data_out,
	input  wire logic                      ready_in
);

	logic                    valid_q;
	bct_pkg::cell_t          data_q;
	bct_pkg::cell_t          nxt;
	logic [bct_pkg::REM_W:0] trial;
	logic                    fits;

	assign ready_out = !valid_q || ready_in;

	// Bring down the next dividend bit and subtract the divisor where it fits.
	always_comb begin
		trial    = {data_in.rem, data_in.word[bct_pkg::FULL_W-1]};
		fits     = trial >= {1'b0, divisor};
		nxt      = data_in;
		nxt.rem  = fits ? bct_pkg::REM_W'(trial - {1'b0, divisor})
			: trial[bct_pkg::REM_W-1:0];
		nxt.word = {data_in.word[bct_pkg::FULL_W-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_out) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_in) data_q <= nxt;
	end

	assign valid_out = valid_q;
	assign data_out  = data_q;

	// A held request stays put while the next cell is busy.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !ready_in |=> valid_q && $stable(data_q))
		else $error("cell dropped or changed a stalled request");

	// A request offered to a free cell is taken.
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		valid_in && ready_out |=> valid_q)
		else $error("cell lost an accepted request");

	// A free cell with nothing offered becomes empty.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_in && ready_out |=> !valid_q)
		else $error("cell invented a request");

endmodule

`default_nettype wire

FILE: tb/block_to_chs_translate_tb.sv
`timescale 1ns / 100ps
// Testbench for block_to_chs_translate: directed and random block numbers checked against a CHS predictor.
module block_to_chs_translate_tb;

	localparam int     HALF_PERIOD      = 5;
	localparam int     RESET_CYCLES     = 12;
	localparam int     PIPE_DRAIN       = 60;
	localparam longint CYCLE_LIMIT      = 1000000;
	localparam int     MAX_PRINTS       = 40;
	localparam int     RANDOM_PHASES    = 12;
	localparam int     PHASE_ITEMS      = 125;
	localparam int     BASE_BLOCK_BYTES = 128;
	localparam int     BLOCK_MAX        = 65535;
	localparam int     SHEAD_MAX        = 15;
	// Register indexes six and seven are not mapped and must be ignored.
	localparam logic [bct_pkg::PADDR_W-1:0] SPARE_ADDR_LO = 5'd24;
	localparam logic [bct_pkg::PADDR_W-1:0] SPARE_ADDR_HI = 5'd28;

	// One disk address as the block returns it.
	typedef struct packed {
		logic [bct_pkg::CYL_W-1:0]    cylinder;
		logic [bct_pkg::HEAD_W-1:0]   head;
		logic [bct_pkg::SECTOR_W-1:0] sector;
	} chs_t;

	// Testbench copy of the geometry registers.
	typedef struct packed {
		logic [bct_pkg::BSHIFT_W-1:0] block_shift;
		logic [bct_pkg::SSHIFT_W-1:0] sector_size_shift;
		logic [bct_pkg::SPT_W-1:0]    track_sectors;
		logic [bct_pkg::HCOUNT_W-1:0] head_count;
		logic [bct_pkg::SCYL_W-1:0]   start_cylinder;
		logic [bct_pkg::SHEAD_W-1:0]  start_head;
	} geometry_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [bct_pkg::PADDR_W-1:0] paddr;
	logic [bct_pkg::PDATA_W-1:0] pwdata;
	logic [bct_pkg::PDATA_W-1:0] prdata;
	logic                        pready;
	logic                        s_axis_tvalid;
	logic                        s_axis_tready;
	logic [15:0]                 s_axis_tdata;   // [15:0] block_number
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [47:0]                 m_axis_tdata;   // [28:0] cylinder, [32:29] head, [40:33] sector

	geometry_t geom = '{block_shift: 3'd2, sector_size_shift: 4'd9, track_sectors: 8'd63,
		head_count: 5'd16, start_cylinder: 16'd0, start_head: 4'd0};
	chs_t      address_q[$];
	int        mismatches = 0;
	longint    cycle_count = 0;
	bit        no_idle = 1'b0;
	int        ready_hold = 0;

	block_to_chs_translate dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Free-running clock.
	always #HALF_PERIOD clk = ~clk;

	// Computes the disk address of a block's first sector from the current geometry.
	function automatic chs_t translate_block(input logic [bct_pkg::BLOCK_W-1:0] blk);
		longint unsigned spb, spt, per_cyl, full, rem_s;
		chs_t a;
		a = '0;
		spt = geom.track_sectors;
		per_cyl = spt * geom.head_count;
		if (per_cyl != 0) begin
			spb = (64'(BASE_BLOCK_BYTES) << geom.block_shift) >> geom.sector_size_shift;
			full = 64'(blk) * spb + 64'(geom.start_head) * spt
				+ 64'(geom.start_cylinder) * per_cyl;
			rem_s = full % per_cyl;
			a.cylinder = bct_pkg::CYL_W'(full / per_cyl);
			a.head = bct_pkg::HEAD_W'(rem_s / spt);
			a.sector = bct_pkg::SECTOR_W'(rem_s % spt);
		end
		return a;
	endfunction

	// Updates the geometry copy after a register write; unmapped indexes are ignored.
	function automatic void apply_reg(input logic [bct_pkg::PADDR_W-1:0] addr,
			input logic [bct_pkg::PDATA_W-1:0] data);
		case (bct_pkg::reg_idx_t'(addr[4:2]))
			bct_pkg::REG_BLOCK_SHIFT:  geom.block_shift = data[bct_pkg::BSHIFT_W-1:0];
			bct_pkg::REG_SECTOR_SHIFT: geom.sector_size_shift = data[bct_pkg::SSHIFT_W-1:0];
			bct_pkg::REG_SPT:          geom.track_sectors = data[bct_pkg::SPT_W-1:0];
			bct_pkg::REG_HEAD_COUNT:   geom.head_count = data[bct_pkg::HCOUNT_W-1:0];
			bct_pkg::REG_START_CYL:    geom.start_cylinder = data[bct_pkg::SCYL_W-1:0];
			bct_pkg::REG_START_HEAD:   geom.start_head = data[bct_pkg::SHEAD_W-1:0];
			default: ;
		endcase
	endfunction

	// Gap length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Random bits above a register's width, which the block must drop.
	function automatic logic [bct_pkg::PDATA_W-1:0] noise_above(input int width, input bit enable);
		logic [bct_pkg::PDATA_W-1:0] n;
		n = $urandom;
		return enable ? (n << width) : '0;
	endfunction

	// Block number biased toward the extremes and single set bits.
	function automatic logic [bct_pkg::BLOCK_W-1:0] pick_block();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return '0;
		if (r < 16) return bct_pkg::BLOCK_W'(BLOCK_MAX);
		if (r < 26) return bct_pkg::BLOCK_W'(1) << $urandom_range(0, bct_pkg::BLOCK_W - 1);
		return bct_pkg::BLOCK_W'($urandom);
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (mismatches < MAX_PRINTS)
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// Receiver side: tready toggles with random hold times unless idling is off.
	always @(negedge clk) begin
		if (no_idle) begin
			m_axis_tready <= 1'b1;
			ready_hold <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (m_axis_tready) begin
			m_axis_tready <= 1'b0;
			ready_hold <= pick_gap();
		end else begin
			m_axis_tready <= 1'b1;
			ready_hold <= $urandom_range(0, 12);
		end
	end

	// Predicts each accepted request and checks each accepted result in order.
	always @(posedge clk) begin : monitor
		chs_t got;
		chs_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.cylinder = m_axis_tdata[28:0];
				got.head = m_axis_tdata[32:29];
				got.sector = m_axis_tdata[40:33];
				if (address_q.size() == 0) begin
					report_mismatch("result with no request waiting, cylinder", got.cylinder, 0);
				end else begin
					want = address_q.pop_front();
					if (got.cylinder !== want.cylinder)
						report_mismatch("cylinder", got.cylinder, want.cylinder);
					if (got.head !== want.head)
						report_mismatch("head", got.head, want.head);
					if (got.sector !== want.sector)
						report_mismatch("sector", got.sector, want.sector);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				address_q.insert(address_q.size(), translate_block(s_axis_tdata));
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[block_to_chs_translate] ERROR");
			$finish;
		end
	end

	// Sends one block number, after a random gap, and waits until it is accepted.
	task automatic send_block(input logic [bct_pkg::BLOCK_W-1:0] blk);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= blk;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Stops sending and waits until every expected address has come back.
	task automatic drain_requests();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (address_q.size() != 0) @(posedge clk);
	endtask

	// One APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic [bct_pkg::PADDR_W-1:0] addr,
			input logic [bct_pkg::PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		apply_reg(addr, data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_reg(input bct_pkg::reg_idx_t idx, input logic [bct_pkg::PDATA_W-1:0] data);
		write_reg({idx, 2'b00}, data);
	endtask

	// Drains the block, then rewrites every geometry register.
	task automatic program_geometry(input int bs, input int ss, input int spt, input int hc,
			input int sc, input int sh, input bit junk, input bit quiet);
		drain_requests();
		no_idle = quiet;
		set_reg(bct_pkg::REG_BLOCK_SHIFT,
			bct_pkg::PDATA_W'(bs) | noise_above(bct_pkg::BSHIFT_W, junk));
		set_reg(bct_pkg::REG_SECTOR_SHIFT,
			bct_pkg::PDATA_W'(ss) | noise_above(bct_pkg::SSHIFT_W, junk));
		set_reg(bct_pkg::REG_SPT,
			bct_pkg::PDATA_W'(spt) | noise_above(bct_pkg::SPT_W, junk));
		set_reg(bct_pkg::REG_HEAD_COUNT,
			bct_pkg::PDATA_W'(hc) | noise_above(bct_pkg::HCOUNT_W, junk));
		set_reg(bct_pkg::REG_START_CYL,
			bct_pkg::PDATA_W'(sc) | noise_above(bct_pkg::SCYL_W, junk));
		set_reg(bct_pkg::REG_START_HEAD,
			bct_pkg::PDATA_W'(sh) | noise_above(bct_pkg::SHEAD_W, junk));
	endtask

	// Default geometry straight out of reset.
	task automatic test_reset_geometry();
		send_block('0);
		send_block(16'd1);
		send_block(bct_pkg::BLOCK_W'(BLOCK_MAX));
		send_block(16'hA5A5);
	endtask

	// Each unusual geometry with a few block numbers.
	task automatic test_special_geometries();
		// Block smaller than a sector: everything lands on the partition start.
		program_geometry(0, 12, 63, 16, 100, 3, 1'b0, 1'b0);
		send_block(bct_pkg::BLOCK_W'(BLOCK_MAX));
		send_block(16'd1);
		// Sector shift above the range still follows the quotient rule.
		program_geometry(7, 15, 63, 16, 7, 2, 1'b0, 1'b0);
		send_block(bct_pkg::BLOCK_W'(BLOCK_MAX));
		// Largest sectors per block with the largest geometry.
		program_geometry(7, 0, 255, 31, 65535, SHEAD_MAX, 1'b0, 1'b0);
		send_block(bct_pkg::BLOCK_W'(BLOCK_MAX));
		// Tiny geometry so the cylinder overflows its width.
		program_geometry(7, 0, 1, 1, 65535, SHEAD_MAX, 1'b0, 1'b0);
		send_block(bct_pkg::BLOCK_W'(BLOCK_MAX));
		// More than sixteen heads: the head keeps only its low bits.
		program_geometry(2, 9, 1, 31, 0, 0, 1'b0, 1'b0);
		send_block(16'd20);
		send_block(16'd30);
		// No sectors per track, then no heads: the address is all zero.
		program_geometry(2, 9, 0, 16, 1234, 5, 1'b0, 1'b0);
		send_block(bct_pkg::BLOCK_W'(BLOCK_MAX));
		send_block(16'd12345);
		program_geometry(2, 9, 63, 0, 1234, 5, 1'b0, 1'b0);
		send_block(bct_pkg::BLOCK_W'(BLOCK_MAX));
		// Start head past the head count carries into the cylinder.
		program_geometry(2, 9, 63, 4, 10, SHEAD_MAX, 1'b0, 1'b0);
		send_block('0);
		send_block(16'd300);
		// Writes to unmapped indexes must leave the geometry alone.
		drain_requests();
		write_reg(SPARE_ADDR_LO, 32'hFFFF_FFFF);
		write_reg(SPARE_ADDR_HI, 32'h0000_0000);
		send_block(16'd777);
	endtask

	// Phases of random traffic, each with its own geometry.
	task automatic test_random_traffic();
		int bs, ss, spt, hc, sc, sh, r;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			bs = $urandom_range(0, 7);
			r = $urandom_range(0, 99);
			ss = (r < 85) ? $urandom_range(7, 12) : $urandom_range(0, 15);
			r = $urandom_range(0, 99);
			spt = (r < 5) ? 0 : (r < 10) ? 255 : $urandom_range(1, 255);
			r = $urandom_range(0, 99);
			hc = (r < 5) ? 0 : (r < 15) ? $urandom_range(17, 31) : $urandom_range(1, 16);
			r = $urandom_range(0, 99);
			sc = (r < 10) ? 0 : (r < 20) ? 65535 : $urandom_range(0, 65535);
			sh = $urandom_range(0, SHEAD_MAX);
			// The first two phases take the register extremes.
			if (phase == 0) begin
				bs = 7; ss = 0; spt = 255; hc = 31; sc = 65535; sh = SHEAD_MAX;
			end else if (phase == 1) begin
				bs = 0; ss = 7; spt = 1; hc = 1; sc = 0; sh = 0;
			end
			program_geometry(bs, ss, spt, hc, sc, sh, $urandom_range(0, 3) == 0,
				(phase % 4) == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Now and then the sender waits until the pipeline is empty.
				if (i == PHASE_ITEMS / 2 && (phase % 2) == 0)
					drain_requests();
				send_block(pick_block());
			end
		end
	endtask

	// Waits for the last results, then gives the verdict.
	task automatic test_wrap_up();
		drain_requests();
		repeat (PIPE_DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("[block_to_chs_translate] OK");
		else
			$display("[block_to_chs_translate] ERROR");
		$finish;
	endtask

	// Reset, then the tests in turn.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_geometry();
		test_special_geometries();
		test_random_traffic();
		test_wrap_up();
	end

endmodule
